// ----- hdl/rsw_pkg.sv -----
package rsw_pkg;

    localparam int MAX_TRIANGLES      = 256;
    localparam int MAX_CONTROL_POINTS = 256;
    localparam int FRACTION_BITS      = 32;

    localparam int TRI_AW  = $clog2(MAX_TRIANGLES);
    localparam int PT_AW   = $clog2(MAX_CONTROL_POINTS);
    localparam int CNT_W   = 9;
    localparam int COORD_W = 32;
    localparam int COEF_W  = 64;
    localparam int D_W     = COORD_W + 1;
    localparam int NUM_W   = 2 * COORD_W + 1;
    localparam int DEN_W   = 2 * D_W + 1;
    localparam int QUO_W   = NUM_W + FRACTION_BITS;
    localparam int DCNT_W  = $clog2(QUO_W + 1);
    localparam int MUL_W   = D_W + 1;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int SACC_W  = COEF_W + COORD_W + 2;
    localparam int SIMP_W  = FRACTION_BITS + 1;
    localparam int MIX_W   = SIMP_W + COORD_W + 5;

    localparam int PT_W      = 4 * COORD_W;
    localparam int TRI_ROW_W = 6 * COEF_W + 3 * PT_AW + 1;
    localparam int VA_LSB    = 6 * COEF_W;
    localparam int DEG_BIT   = 6 * COEF_W + 3 * PT_AW;

    localparam int S_DATA_W = 160;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 72;
    localparam int HIT_LSB  = 2 * COORD_W;

    localparam logic [1:0] CMD_POINT = 2'd0;
    localparam logic [1:0] CMD_TRI   = 2'd1;
    localparam logic [1:0] CMD_XFORM = 2'd2;

endpackage

// ----- hdl/rsw_div.sv -----
module rsw_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [rsw_pkg::NUM_W-1:0]   num,
    input  logic signed [rsw_pkg::DEN_W-1:0]   den,
    output logic                               done,
    output logic signed [rsw_pkg::COEF_W-1:0]  quo
);
    import rsw_pkg::*;

    localparam logic [QUO_W-1:0] MIN_MAG = QUO_W'(1) << (COEF_W - 1);
    localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] COEF_MIN = ~COEF_MAX;

    logic [QUO_W-1:0]  dvd_reg;
    logic [DEN_W:0]    rem_reg;
    logic [DEN_W-1:0]  dmag_reg;
    logic              neg_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              done_reg;

    logic [NUM_W-1:0]  nmag;
    logic [DEN_W-1:0]  dmag;
    logic [DEN_W:0]    rem_sh;
    logic              take;

    assign nmag   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign dmag   = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
    assign rem_sh = {rem_reg[DEN_W-1:0], dvd_reg[QUO_W-1]};
    assign take   = rem_sh >= {1'b0, dmag_reg};

    // one quotient bit per cycle, restoring
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                cnt_reg <= DCNT_W'(QUO_W);
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DCNT_W'(1))
                    done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg  <= {nmag, {FRACTION_BITS{1'b0}}};
            rem_reg  <= '0;
            dmag_reg <= dmag;
            neg_reg  <= num[NUM_W-1] ^ den[DEN_W-1];
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= take ? rem_sh - {1'b0, dmag_reg} : rem_sh;
            dvd_reg <= {dvd_reg[QUO_W-2:0], take};
        end
    end

    // sign and saturate to the coefficient width
    always_comb
    begin
        if (neg_reg)
        begin
            if (dvd_reg > MIN_MAG)
                quo = COEF_MIN;
            else
                quo = -$signed(dvd_reg[COEF_W-1:0]);
        end
        else
        begin
            if (dvd_reg >= MIN_MAG)
                quo = COEF_MAX;
            else
                quo = $signed(dvd_reg[COEF_W-1:0]);
        end
    end

    assign done = done_reg;

endmodule

// ----- hdl/triangle_rubber_sheet_warp_top.sv -----
// point load: written straight into the point store; triangle load: six coefficient divisions
// (97 quotient bits each) in the shared restoring divider, none for a degenerate triangle
// transform: each non-degenerate triangle searched uses one shared 34x34 multiplier
// doing eight partial products, a degenerate one is skipped, and a hit blends the moved corners;
// one item in flight at a time, a finished result waits in the output register
// reset (rst_n, async, active low) clears the triangle count and control state only
module triangle_rubber_sheet_warp_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // slot, point_x, point_y, target_x, target_y, vertex_a, vertex_b, vertex_c
    input  logic [rsw_pkg::S_DATA_W-1:0]    s_tdata,
    // cmd
    input  logic [rsw_pkg::S_USER_W-1:0]    s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_x, out_y, hit_triangle
    output logic [rsw_pkg::M_DATA_W-1:0]    m_tdata,
    // inside_res
    output logic [0:0]                      m_tuser,
    input  logic                            cfg_we,
    input  logic [rsw_pkg::CNT_W-1:0]       cfg_wdata
);
    import rsw_pkg::*;

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_LA   = 5'd1;
    localparam logic [4:0] ST_LB   = 5'd2;
    localparam logic [4:0] ST_LC   = 5'd3;
    localparam logic [4:0] ST_LD   = 5'd4;
    localparam logic [4:0] ST_LMUL = 5'd5;
    localparam logic [4:0] ST_LDIV = 5'd6;
    localparam logic [4:0] ST_LWR  = 5'd7;
    localparam logic [4:0] ST_TRD  = 5'd8;
    localparam logic [4:0] ST_TCHK = 5'd9;
    localparam logic [4:0] ST_TMUL = 5'd10;
    localparam logic [4:0] ST_TTST = 5'd11;
    localparam logic [4:0] ST_PA   = 5'd12;
    localparam logic [4:0] ST_PB   = 5'd13;
    localparam logic [4:0] ST_PC   = 5'd14;
    localparam logic [4:0] ST_PD   = 5'd15;
    localparam logic [4:0] ST_MIX  = 5'd16;
    localparam logic [4:0] ST_MFIN = 5'd17;
    localparam logic [4:0] ST_OUT  = 5'd18;

    localparam logic signed [SACC_W:0] ONE_W = (SACC_W+1)'(1) << FRACTION_BITS;
    localparam logic [SIMP_W-1:0] ONE_S = SIMP_W'(1) << FRACTION_BITS;
    localparam logic signed [MIX_W-1:0] RND = (MIX_W'(1) << FRACTION_BITS) - 1'b1;

    // control
    logic [4:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] tcur_reg, tlim_reg;
    logic [3:0]       ms_reg;
    logic [2:0]       ci_reg;
    logic             dgo_reg;
    logic             m_valid_reg;

    // payload
    logic [PT_AW-1:0]          va_reg, vb_reg, vc_reg;
    logic [TRI_AW-1:0]         slot_reg;
    logic signed [COORD_W-1:0] px_reg, py_reg;
    logic signed [COORD_W-1:0] vx_reg [0:2];
    logic signed [COORD_W-1:0] vy_reg [0:2];
    logic signed [PROD_W-1:0]  mul_p_reg, tmp_reg;
    logic signed [DEN_W-1:0]   t_reg;
    logic signed [NUM_W-1:0]   n2_reg, n5_reg;
    logic signed [COEF_W-1:0]  coef_reg [0:5];
    logic                      deg_reg;
    logic signed [SACC_W-1:0]  acc1_reg, acc2_reg;
    logic [SIMP_W-1:0]         s1_reg, s2_reg, s3_reg;
    logic signed [MIX_W-1:0]   mx_reg, my_reg;
    logic [COORD_W-1:0]        res_x_reg, res_y_reg;
    logic                      res_in_reg;
    logic [TRI_AW-1:0]         res_hit_reg;
    logic [COORD_W-1:0]        m_x_reg, m_y_reg;
    logic                      m_in_reg;
    logic [TRI_AW-1:0]         m_hit_reg;

    // memories
    logic [PT_W-1:0]      pt_mem [0:MAX_CONTROL_POINTS-1];
    logic [PT_W-1:0]      pt_q_reg;
    logic [TRI_ROW_W-1:0] tri_mem [0:MAX_TRIANGLES-1];
    logic [TRI_ROW_W-1:0] tri_q_reg;
    logic [PT_AW-1:0]     pt_ra;

    logic                      s_acc;
    logic signed [D_W-1:0]     d_bxax, d_cyay, d_cxax, d_byay, d_cxbx, d_bycy, d_axcx;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [NUM_W-1:0]   div_num;
    logic                      div_done;
    logic signed [COEF_W-1:0]  div_quo;
    logic signed [COEF_W-1:0]  k_sel;
    logic [PT_AW-1:0]          tva, tvb, tvc;
    logic signed [SACC_W-1:0]  term;
    logic signed [SACC_W:0]    s_sum;
    logic                      t_hit;
    logic signed [MIX_W-1:0]   mx_adj, my_adj;
    logic                      out_free;

    assign s_acc    = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_tready;

    assign tva = tri_q_reg[VA_LSB +: PT_AW];
    assign tvb = tri_q_reg[VA_LSB + PT_AW +: PT_AW];
    assign tvc = tri_q_reg[VA_LSB + 2*PT_AW +: PT_AW];

    // corner differences on the original positions
    assign d_bxax = D_W'(vx_reg[1]) - D_W'(vx_reg[0]);
    assign d_cyay = D_W'(vy_reg[2]) - D_W'(vy_reg[0]);
    assign d_cxax = D_W'(vx_reg[2]) - D_W'(vx_reg[0]);
    assign d_byay = D_W'(vy_reg[1]) - D_W'(vy_reg[0]);
    assign d_cxbx = D_W'(vx_reg[2]) - D_W'(vx_reg[1]);
    assign d_bycy = D_W'(vy_reg[1]) - D_W'(vy_reg[2]);
    assign d_axcx = D_W'(vx_reg[0]) - D_W'(vx_reg[2]);

    // point memory read address follows the corner being fetched
    always_comb
    begin
        case (state_reg)
            ST_LA:   pt_ra = va_reg;
            ST_LB:   pt_ra = vb_reg;
            ST_LC:   pt_ra = vc_reg;
            ST_PA:   pt_ra = tva;
            ST_PB:   pt_ra = tvb;
            ST_PC:   pt_ra = tvc;
            default: pt_ra = va_reg;
        endcase
    end

    // control point store: original x,y then moved x,y
    always_ff @(posedge clk)
    begin
        if (s_acc && s_tuser == CMD_POINT)
            pt_mem[s_tdata[PT_AW-1:0]] <= s_tdata[8 +: PT_W];
        pt_q_reg <= pt_mem[pt_ra];
    end

    // triangle store: six coefficients, corner indices, degenerate flag
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LWR)
            tri_mem[slot_reg] <= {deg_reg, vc_reg, vb_reg, va_reg,
                                  coef_reg[5], coef_reg[4], coef_reg[3],
                                  coef_reg[2], coef_reg[1], coef_reg[0]};
        tri_q_reg <= tri_mem[tcur_reg[TRI_AW-1:0]];
    end

    // coefficient feeding the search multiply: A1, B1, A2, B2 in turn
    always_comb
    begin
        case (ms_reg[2:1])
            2'd0:    k_sel = $signed(tri_q_reg[0*COEF_W +: COEF_W]);
            2'd1:    k_sel = $signed(tri_q_reg[1*COEF_W +: COEF_W]);
            2'd2:    k_sel = $signed(tri_q_reg[3*COEF_W +: COEF_W]);
            default: k_sel = $signed(tri_q_reg[4*COEF_W +: COEF_W]);
        endcase
    end

    // shared multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_LMUL:
            begin
                case (ms_reg)
                    4'd0:    begin mul_a = MUL_W'(d_bxax);    mul_b = MUL_W'(d_cyay);    end
                    4'd1:    begin mul_a = MUL_W'(d_cxax);    mul_b = MUL_W'(d_byay);    end
                    4'd2:    begin mul_a = MUL_W'(vx_reg[1]); mul_b = MUL_W'(vy_reg[2]); end
                    4'd3:    begin mul_a = MUL_W'(vx_reg[2]); mul_b = MUL_W'(vy_reg[1]); end
                    4'd4:    begin mul_a = MUL_W'(vx_reg[2]); mul_b = MUL_W'(vy_reg[0]); end
                    default: begin mul_a = MUL_W'(vx_reg[0]); mul_b = MUL_W'(vy_reg[2]); end
                endcase
            end
            ST_TMUL:
            begin
                // even steps take the upper half (signed), odd the lower half (unsigned)
                if (ms_reg[0])
                    mul_a = $signed({2'b00, k_sel[COORD_W-1:0]});
                else
                    mul_a = MUL_W'($signed(k_sel[COEF_W-1:COORD_W]));
                mul_b = ms_reg[1] ? MUL_W'(px_reg) : MUL_W'(py_reg);
            end
            ST_MIX:
            begin
                case (ms_reg)
                    4'd0:    begin mul_a = $signed({1'b0, s1_reg}); mul_b = MUL_W'(vx_reg[0]); end
                    4'd1:    begin mul_a = $signed({1'b0, s2_reg}); mul_b = MUL_W'(vx_reg[1]); end
                    4'd2:    begin mul_a = $signed({1'b0, s3_reg}); mul_b = MUL_W'(vx_reg[2]); end
                    4'd3:    begin mul_a = $signed({1'b0, s1_reg}); mul_b = MUL_W'(vy_reg[0]); end
                    4'd4:    begin mul_a = $signed({1'b0, s2_reg}); mul_b = MUL_W'(vy_reg[1]); end
                    default: begin mul_a = $signed({1'b0, s3_reg}); mul_b = MUL_W'(vy_reg[2]); end
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        mul_p_reg <= mul_a * mul_b;
    end

    // numerator for the coefficient being divided
    always_comb
    begin
        case (ci_reg)
            3'd0:    div_num = NUM_W'(d_cxbx);
            3'd1:    div_num = NUM_W'(d_bycy);
            3'd2:    div_num = n2_reg;
            3'd3:    div_num = NUM_W'(d_axcx);
            3'd4:    div_num = NUM_W'(d_cyay);
            default: div_num = n5_reg;
        endcase
    end

    rsw_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dgo_reg),
        .num   (div_num),
        .den   (t_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    // partial product weight: upper-half products sit FRACTION_BITS higher
    assign term  = ms_reg[0] ? (SACC_W'(mul_p_reg) <<< FRACTION_BITS) : SACC_W'(mul_p_reg);
    assign s_sum = (SACC_W+1)'(acc1_reg) + (SACC_W+1)'(acc2_reg);
    assign t_hit = !acc1_reg[SACC_W-1] && !acc2_reg[SACC_W-1] && (s_sum <= ONE_W);

    // truncate toward zero on the way out of the fraction
    assign mx_adj = mx_reg + (mx_reg[MIX_W-1] ? RND : '0);
    assign my_adj = my_reg + (my_reg[MIX_W-1] ? RND : '0);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_acc && s_tuser == CMD_TRI)
                    state_next = ST_LA;
                else if (s_acc && s_tuser == CMD_XFORM)
                    state_next = ST_TRD;
            end
            ST_LA:   state_next = ST_LB;
            ST_LB:   state_next = ST_LC;
            ST_LC:   state_next = ST_LD;
            ST_LD:   state_next = ST_LMUL;
            ST_LMUL:
            begin
                if (ms_reg == 4'd6)
                    state_next = (t_reg == '0) ? ST_LWR : ST_LDIV;
            end
            ST_LDIV:
            begin
                if (div_done && ci_reg == 3'd5)
                    state_next = ST_LWR;
            end
            ST_LWR:  state_next = ST_IDLE;
            ST_TRD:  state_next = (tcur_reg == tlim_reg) ? ST_OUT : ST_TCHK;
            ST_TCHK: state_next = tri_q_reg[DEG_BIT] ? ST_TRD : ST_TMUL;
            ST_TMUL:
            begin
                if (ms_reg == 4'd8)
                    state_next = ST_TTST;
            end
            ST_TTST: state_next = t_hit ? ST_PA : ST_TRD;
            ST_PA:   state_next = ST_PB;
            ST_PB:   state_next = ST_PC;
            ST_PC:   state_next = ST_PD;
            ST_PD:   state_next = ST_MIX;
            ST_MIX:
            begin
                if (ms_reg == 4'd6)
                    state_next = ST_MFIN;
            end
            ST_MFIN: state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            tcur_reg    <= '0;
            tlim_reg    <= '0;
            ms_reg      <= '0;
            ci_reg      <= '0;
            dgo_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dgo_reg   <= 1'b0;

            if (cfg_we)
                count_reg <= cfg_wdata;

            case (state_reg)
                ST_IDLE:
                begin
                    tcur_reg <= '0;
                    tlim_reg <= (count_reg > CNT_W'(MAX_TRIANGLES)) ?
                                CNT_W'(MAX_TRIANGLES) : count_reg;
                end
                ST_LD:   ms_reg <= '0;
                ST_LMUL:
                begin
                    ms_reg <= ms_reg + 1'b1;
                    if (ms_reg == 4'd6)
                    begin
                        ci_reg  <= '0;
                        dgo_reg <= (t_reg != '0);
                    end
                end
                ST_LDIV:
                begin
                    if (div_done && ci_reg != 3'd5)
                    begin
                        ci_reg  <= ci_reg + 1'b1;
                        dgo_reg <= 1'b1;
                    end
                end
                ST_TCHK:
                begin
                    ms_reg <= '0;
                    if (tri_q_reg[DEG_BIT])
                        tcur_reg <= tcur_reg + 1'b1;
                end
                ST_TMUL: ms_reg <= ms_reg + 1'b1;
                ST_TTST:
                begin
                    if (!t_hit)
                        tcur_reg <= tcur_reg + 1'b1;
                end
                ST_PD:   ms_reg <= '0;
                ST_MIX:  ms_reg <= ms_reg + 1'b1;
                default: ;
            endcase

            // output register: a new result loads when the old one has gone
            if (state_reg == ST_OUT && out_free)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            slot_reg <= s_tdata[TRI_AW-1:0];
            px_reg   <= $signed(s_tdata[8 +: COORD_W]);
            py_reg   <= $signed(s_tdata[8+COORD_W +: COORD_W]);
            va_reg   <= s_tdata[8+4*COORD_W +: PT_AW];
            vb_reg   <= s_tdata[8+4*COORD_W+8 +: PT_AW];
            vc_reg   <= s_tdata[8+4*COORD_W+16 +: PT_AW];
        end

        case (state_reg)
            ST_LB:
            begin
                vx_reg[0] <= $signed(pt_q_reg[0 +: COORD_W]);
                vy_reg[0] <= $signed(pt_q_reg[COORD_W +: COORD_W]);
            end
            ST_LC:
            begin
                vx_reg[1] <= $signed(pt_q_reg[0 +: COORD_W]);
                vy_reg[1] <= $signed(pt_q_reg[COORD_W +: COORD_W]);
            end
            ST_LD:
            begin
                vx_reg[2] <= $signed(pt_q_reg[0 +: COORD_W]);
                vy_reg[2] <= $signed(pt_q_reg[COORD_W +: COORD_W]);
            end
            ST_LMUL:
            begin
                // pairs of products: first is held, second is subtracted
                if (ms_reg != 4'd0)
                begin
                    case (ms_reg)
                        4'd1, 4'd3, 4'd5: tmp_reg <= mul_p_reg;
                        4'd2:    t_reg  <= DEN_W'(tmp_reg - mul_p_reg);
                        4'd4:    n2_reg <= NUM_W'(tmp_reg - mul_p_reg);
                        default: n5_reg <= NUM_W'(tmp_reg - mul_p_reg);
                    endcase
                end
                if (ms_reg == 4'd6)
                begin
                    deg_reg <= (t_reg == '0);
                    for (int i = 0; i < 6; i++)
                        coef_reg[i] <= '0;
                end
            end
            ST_LDIV:
            begin
                if (div_done)
                    coef_reg[ci_reg] <= div_quo;
            end
            ST_TRD:
            begin
                // no triangle holds the point: pass it through
                res_x_reg   <= px_reg;
                res_y_reg   <= py_reg;
                res_in_reg  <= 1'b0;
                res_hit_reg <= '0;
            end
            ST_TCHK:
            begin
                acc1_reg <= SACC_W'($signed(tri_q_reg[2*COEF_W +: COEF_W]));
                acc2_reg <= SACC_W'($signed(tri_q_reg[5*COEF_W +: COEF_W]));
            end
            ST_TMUL:
            begin
                if (ms_reg != 4'd0)
                begin
                    if (ms_reg <= 4'd4)
                        acc1_reg <= acc1_reg + term;
                    else
                        acc2_reg <= acc2_reg + term;
                end
            end
            ST_TTST:
            begin
                s1_reg <= acc1_reg[SIMP_W-1:0];
                s2_reg <= acc2_reg[SIMP_W-1:0];
                s3_reg <= ONE_S - acc1_reg[SIMP_W-1:0] - acc2_reg[SIMP_W-1:0];
            end
            ST_PB:
            begin
                vx_reg[0] <= $signed(pt_q_reg[2*COORD_W +: COORD_W]);
                vy_reg[0] <= $signed(pt_q_reg[3*COORD_W +: COORD_W]);
            end
            ST_PC:
            begin
                vx_reg[1] <= $signed(pt_q_reg[2*COORD_W +: COORD_W]);
                vy_reg[1] <= $signed(pt_q_reg[3*COORD_W +: COORD_W]);
            end
            ST_PD:
            begin
                vx_reg[2] <= $signed(pt_q_reg[2*COORD_W +: COORD_W]);
                vy_reg[2] <= $signed(pt_q_reg[3*COORD_W +: COORD_W]);
                mx_reg    <= '0;
                my_reg    <= '0;
            end
            ST_MIX:
            begin
                if (ms_reg != 4'd0)
                begin
                    if (ms_reg <= 4'd3)
                        mx_reg <= mx_reg + MIX_W'(mul_p_reg);
                    else
                        my_reg <= my_reg + MIX_W'(mul_p_reg);
                end
            end
            ST_MFIN:
            begin
                res_x_reg   <= mx_adj[FRACTION_BITS +: COORD_W];
                res_y_reg   <= my_adj[FRACTION_BITS +: COORD_W];
                res_in_reg  <= 1'b1;
                res_hit_reg <= tcur_reg[TRI_AW-1:0];
            end
            default: ;
        endcase

        if (state_reg == ST_OUT && out_free)
        begin
            m_x_reg   <= res_x_reg;
            m_y_reg   <= res_y_reg;
            m_in_reg  <= res_in_reg;
            m_hit_reg <= res_hit_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_hit_reg, m_y_reg, m_x_reg};
    assign m_tuser  = m_in_reg;

endmodule

// ----- hdl/rsw_chk.sv -----
module rsw_chk (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [rsw_pkg::S_DATA_W-1:0]    s_tdata,
    input logic [rsw_pkg::S_USER_W-1:0]    s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [rsw_pkg::M_DATA_W-1:0]    m_tdata,
    input logic [0:0]                      m_tuser,
    input logic                            cfg_we,
    input logic [rsw_pkg::CNT_W-1:0]       cfg_wdata
);
    import rsw_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a miss reports triangle zero
    a_miss_hit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[HIT_LSB +: TRI_AW] == '0)
        else $error("miss with nonzero triangle index");

    // a transform keeps the input closed while it searches
    a_xform_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == CMD_XFORM |=> !s_tready)
        else $error("input open right after a transform transfer");

    // a control point load finishes in its own cycle
    a_point_fast: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == CMD_POINT |=> s_tready)
        else $error("input closed after a control point transfer");

endmodule

bind triangle_rubber_sheet_warp_top rsw_chk u_rsw_chk (.*);
